// ----- hdl/mhpq_pkg.sv -----
// Shared types and constants for the min-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [KEY_W-1:0] key;
    } cell_cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                    gt;
        logic                    vld;
        logic signed [KEY_W-1:0] val;
    } cell_link_t;

    // next contents of a cell
    typedef struct packed {
        logic                    vld;
        logic signed [KEY_W-1:0] val;
    } cell_next_t;

endpackage

// ----- hdl/mhpq_cell.sv -----
// One slot of the sorted cell chain: compare with the broadcast key and shift.
module mhpq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  mhpq_pkg::cell_cmd_t cmd,
    input  mhpq_pkg::cell_link_t left_link,
    input  mhpq_pkg::cell_link_t right_link,
    output mhpq_pkg::cell_link_t link,
    output mhpq_pkg::cell_next_t nxt
);

    logic                             vld_reg, vld_next;
    logic signed [mhpq_pkg::KEY_W-1:0] val_reg, val_next;
    logic                             gt;

    assign gt = !vld_reg || (val_reg > cmd.key);

    always_comb begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (cmd.ins && gt) begin
            if (left_link.gt) begin
                vld_next = left_link.vld;
                val_next = left_link.val;
            end else begin
                vld_next = 1'b1;
                val_next = cmd.key;
            end
        end else if (cmd.rem) begin
            vld_next = right_link.vld;
            val_next = right_link.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign link.gt  = gt;
    assign link.vld = vld_reg;
    assign link.val = val_reg;
    assign nxt.vld  = vld_next;
    assign nxt.val  = val_next;

endmodule

// ----- hdl/min_heap_priority_queue.sv -----
// Top level of the min-heap priority queue: sorted cell chain and result register.
//
//  channel  dir  tdata                                   tuser
//  s_       in   value[31:0]                             op
//  m_       out  min_value[31:0] count[39:32] empty[40]  status[1:0]
//
// One item per cycle while s_tready is high; each cell compares and shifts in the same cycle.
// The result is registered and appears in the cycle after the item is accepted.
// Reset clears all cell valid bits and the count at once.
// s_tready drops only while a result waits and m_tready is low.
module min_heap_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // min_value[31:0], count[39:32], empty_res[40], zeros
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int N = mhpq_pkg::CAPACITY;

    mhpq_pkg::cell_cmd_t  cmd;
    mhpq_pkg::cell_link_t links [N];
    mhpq_pkg::cell_next_t nxts  [N];

    logic [mhpq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         m_tvalid_reg;
    logic [47:0]                  m_tdata_reg, m_tdata_next;
    logic [1:0]                   m_tuser_reg, m_tuser_next;
    logic                         accept, full, none;
    logic signed [mhpq_pkg::KEY_W-1:0] min_value;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == mhpq_pkg::COUNT_W'(N));
    assign none     = (count_reg == '0);

    assign cmd.ins = accept && (s_tuser == mhpq_pkg::OP_INSERT) && !full;
    assign cmd.rem = accept && (s_tuser == mhpq_pkg::OP_REMOVE) && !none;
    assign cmd.key = s_tdata;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_cell
            mhpq_pkg::cell_link_t l_in, r_in;
            if (i == 0) begin : g_first
                assign l_in = '0;
            end else begin : g_mid_l
                assign l_in = links[i-1];
            end
            if (i == N-1) begin : g_last
                assign r_in = '0;
            end else begin : g_mid_r
                assign r_in = links[i+1];
            end
            mhpq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .left_link  (l_in),
                .right_link (r_in),
                .link       (links[i]),
                .nxt        (nxts[i])
            );
        end
    endgenerate

    always_comb begin
        count_next   = count_reg;
        m_tuser_next = mhpq_pkg::ST_OK;
        if (s_tuser == mhpq_pkg::OP_INSERT) begin
            if (full) begin
                m_tuser_next = mhpq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (none) begin
                m_tuser_next = mhpq_pkg::ST_EMPTY;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    assign min_value    = nxts[0].vld ? nxts[0].val : '0;
    assign m_tdata_next = {7'd0, (count_next == '0), count_next, min_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mhpq_pkg::COUNT_W'(N))
        else $error("entry count above capacity");

    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        links[0].vld == (count_reg != '0))
        else $error("head cell valid disagrees with count");

    a_tail_matches_full: assert property (@(posedge aclk) disable iff (!aresetn)
        links[N-1].vld == full)
        else $error("tail cell valid disagrees with full");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mhpq_pkg::ST_FULL) |-> m_tdata[39:32] == 8'(N))
        else $error("full status without full count");

endmodule

// ----- tb/tb_min_heap_priority_queue.sv -----
// Self-checking testbench for the min-heap priority queue: directed table, then random phases.
`timescale 1ns / 100ps

module tb_min_heap_priority_queue;

    localparam int CAPACITY = mhpq_pkg::CAPACITY;
    localparam int KEY_W    = mhpq_pkg::KEY_W;
    localparam int COUNT_W  = mhpq_pkg::COUNT_W;

    localparam logic OP_INSERT = mhpq_pkg::OP_INSERT;
    localparam logic OP_REMOVE = mhpq_pkg::OP_REMOVE;

    localparam logic [1:0] ST_OK    = mhpq_pkg::ST_OK;
    localparam logic [1:0] ST_FULL  = mhpq_pkg::ST_FULL;
    localparam logic [1:0] ST_EMPTY = mhpq_pkg::ST_EMPTY;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 1100;
    localparam int LIMIT      = 500000;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic signed [KEY_W-1:0] min_value;
        logic [COUNT_W-1:0]      count;
        logic                    empty_res;
        logic [1:0]              status;
    } heap_result_t;

    typedef struct packed {
        logic                    op;
        logic [KEY_W-1:0]        key;
        logic                    typed;
        heap_result_t            res;
    } dir_row_t;

    // typed rows: result read straight off the operation sequence
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        {OP_REMOVE, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'd0, 1'b1, ST_EMPTY},
        {OP_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 8'd1, 1'b0, ST_OK},
        {OP_INSERT, 32'h8000_0000, 1'b1, 32'h8000_0000, 8'd2, 1'b0, ST_OK},
        {OP_REMOVE, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 8'd1, 1'b0, ST_OK},
        {OP_REMOVE, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'd0, 1'b1, ST_OK},
        {OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 8'd0, 1'b1, ST_EMPTY},
        {OP_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'd1, 1'b0, ST_OK},
        {OP_INSERT, 32'hFFFF_FFFF, 1'b0, 43'h0},
        {OP_INSERT, 32'h0000_0001, 1'b0, 43'h0},
        {OP_INSERT, 32'h0000_0005, 1'b0, 43'h0},
        {OP_INSERT, 32'h0000_0005, 1'b0, 43'h0},
        {OP_INSERT, 32'h8000_0000, 1'b0, 43'h0},
        {OP_INSERT, 32'h7FFF_FFFF, 1'b0, 43'h0},
        {OP_INSERT, 32'hAAAA_AAAA, 1'b0, 43'h0},
        {OP_INSERT, 32'h5555_5555, 1'b0, 43'h0},
        {OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b0, 43'h0},
        {OP_REMOVE, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'd0, 1'b1, ST_EMPTY}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'h0;
    logic        s_tuser  = OP_INSERT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    int           held_keys[$];
    heap_result_t expected_q[$];
    int  errors         = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  full_refused   = 0;
    int  empty_removed  = 0;
    int  peak_count     = 0;
    int  cycles         = 0;
    int  stall_left     = 0;
    bit  no_idle        = 1'b0;

    min_heap_priority_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN) $display("%s", msg);
    endfunction

    function automatic int lowest_pos();
        int pos;
        pos = 0;
        for (int i = 1; i < held_keys.size(); i++)
            if (held_keys[i] < held_keys[pos]) pos = i;
        return pos;
    endfunction

    // applies one operation to the held multiset and returns what the queue reports
    function automatic heap_result_t heap_update(input logic op, input logic [31:0] key);
        heap_result_t r;
        int n;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (held_keys.size() >= CAPACITY) r.status = ST_FULL;
            else held_keys.push_back(int'(key));
        end else begin
            if (held_keys.size() == 0) r.status = ST_EMPTY;
            else held_keys.delete(lowest_pos());
        end
        n = held_keys.size();
        r.min_value = (n > 0) ? held_keys[lowest_pos()] : 32'sh0;
        r.count     = COUNT_W'(n);
        r.empty_res = (n == 0);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] rand_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom;
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return 32'($urandom_range(0, 16)) - 32'd8;
    endfunction

    task automatic send_item(input logic op, input logic [31:0] key,
                             input logic typed, input heap_result_t typed_res);
        heap_result_t predicted;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = heap_update(op, key);
        expected_q.push_back(typed ? typed_res : predicted);
        items_sent++;
        if (predicted.status == ST_FULL)  full_refused++;
        if (predicted.status == ST_EMPTY) empty_removed++;
        if (held_keys.size() > peak_count) peak_count = held_keys.size();
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(input logic op, input logic [31:0] key);
        send_item(op, key, 1'b0, '0);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 15) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        heap_result_t got;
        heap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.min_value = m_tdata[31:0];
            got.count     = m_tdata[39:32];
            got.empty_res = m_tdata[40];
            got.status    = m_tuser;
            results_seen++;
            if (expected_q.size() == 0) begin
                note_error($sformatf("unexpected result: min %0d count %0d empty %0b status %0d",
                           got.min_value, got.count, got.empty_res, got.status));
            end else begin
                want = expected_q.pop_front();
                if (got.min_value !== want.min_value || got.count !== want.count ||
                    got.empty_res !== want.empty_res || got.status !== want.status)
                    note_error($sformatf(
                        "result %0d: exp min %0d count %0d empty %0b status %0d, got min %0d count %0d empty %0b status %0d",
                        results_seen, want.min_value, want.count, want.empty_res,
                        want.status, got.min_value, got.count, got.empty_res, got.status));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[min_heap_priority_queue] ERROR");
            $finish;
        end
    end

    initial begin
        int phase;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].res);
        hold_until_drained();

        while (items_sent < N_DIRECTED + N_RANDOM) begin
            phase   = $urandom_range(0, 5);
            no_idle = ($urandom_range(0, 3) == 0);
            case (phase)
                0, 1: begin
                    // fill up, then knock on a full queue
                    while (held_keys.size() < CAPACITY)
                        send_random(($urandom_range(0, 9) == 0) ? OP_REMOVE : OP_INSERT,
                                    rand_key());
                    repeat ($urandom_range(1, 4)) send_random(OP_INSERT, rand_key());
                end
                2, 3: begin
                    while (held_keys.size() > 0)
                        send_random(($urandom_range(0, 9) == 0) ? OP_INSERT : OP_REMOVE,
                                    rand_key());
                    repeat ($urandom_range(1, 3)) send_random(OP_REMOVE, rand_key());
                end
                4: begin
                    repeat (40) send_random($urandom_range(0, 1) ? OP_REMOVE : OP_INSERT,
                                            rand_key());
                end
                default: begin
                    // narrow key range for many equal keys
                    repeat (40) send_random(($urandom_range(0, 9) < 6) ? OP_INSERT : OP_REMOVE,
                                            32'($urandom_range(0, 8)) - 32'd4);
                end
            endcase
            if ($urandom_range(0, 2) == 0) hold_until_drained();
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d items sent, %0d results checked, peak occupancy %0d of %0d",
                 items_sent, results_seen, peak_count, CAPACITY);
        $display("%0d inserts refused when full, %0d removes on empty, %0d mismatches",
                 full_refused, empty_removed, errors);
        if (errors == 0) begin
            $display("[min_heap_priority_queue] OK");
        end else begin
            $display("[min_heap_priority_queue] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mhpq_pkg.sv
hdl/mhpq_cell.sv
hdl/min_heap_priority_queue.sv
tb/tb_min_heap_priority_queue.sv
